// ===== rtl/core/distance_constraint_solver_top_assert.svh =====
// assertion macros for the distance constraint solver
`ifndef DISTANCE_CONSTRAINT_SOLVER_TOP_ASSERT_SVH
`define DISTANCE_CONSTRAINT_SOLVER_TOP_ASSERT_SVH

// same-cycle implication
`define DCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dcs_pkg.sv =====
// shared types, constants and widths of the distance constraint solver
`default_nettype none

package dcs_pkg;

  localparam int POS_BITS   = 24;
  localparam int MASS_BITS  = 16;
  localparam int REST_W     = 23;
  localparam int STR_W      = 12;
  localparam int MAG_W      = POS_BITS + 1;
  localparam int NSQ_W      = 2 * MAG_W;
  localparam int STR_FRAC2  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;
  localparam int WQ_DEPTH   = 4;
  localparam int OQ_DEPTH   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_REST    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRETCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TENSION = 2'd2;

  typedef struct packed {
    logic signed [POS_BITS-1:0] body1_x;
    logic signed [POS_BITS-1:0] body1_y;
    logic signed [POS_BITS-1:0] body2_x;
    logic signed [POS_BITS-1:0] body2_y;
    logic [MASS_BITS-1:0]       body1_mass;
    logic [MASS_BITS-1:0]       body2_mass;
  } dcs_in_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] move1_x;
    logic signed [POS_BITS-1:0] move1_y;
    logic signed [POS_BITS-1:0] move2_x;
    logic signed [POS_BITS-1:0] move2_y;
    logic                       broken;
    logic                       moved;
  } dcs_out_t;

  typedef struct packed {
    logic [MAG_W-1:0]     ax;
    logic [MAG_W-1:0]     ay;
    logic                 vx_neg;
    logic                 vy_neg;
    logic [NSQ_W-1:0]     nsq;
    logic [MASS_BITS-1:0] m1;
    logic [MASS_BITS-1:0] m2;
  } dcs_work_t;

  typedef struct packed {
    logic [REST_W-1:0] rest_length;
    logic [STR_W-1:0]  max_stretch;
    logic              only_tension;
  } dcs_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIM,
    ST_L0,
    ST_L1,
    ST_L2,
    ST_L3,
    ST_BRK,
    ST_SQRT,
    ST_DELTA,
    ST_MUL,
    ST_DLD,
    ST_DIV,
    ST_RND,
    ST_FIN
  } dcs_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/dcs_fifo.sv =====
// small first-in first-out queue with push/full and pop/empty sides
`default_nettype none

module dcs_fifo #(
  parameter type data_t = logic,
  parameter int  DEPTH  = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  output logic       full,
  input  wire data_t din,
  input  wire logic  pop,
  output logic       empty,
  output data_t      dout
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  data_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dcs_front.sv =====
// front end: separation vector, magnitudes and squared distance, one transaction a cycle while the work queue has room
`default_nettype none

module dcs_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire dcs_pkg::dcs_in_t in_data,
  output logic                  wq_push,
  input  wire logic             wq_full,
  output dcs_pkg::dcs_work_t    wq_data
);

  localparam int MAG_W = dcs_pkg::MAG_W;
  localparam int NSQ_W = dcs_pkg::NSQ_W;

  logic                        en;
  logic                        s1_valid_r, s2_valid_r;
  logic signed [MAG_W-1:0]     vx_c, vy_c;
  logic [MAG_W-1:0]            ax_c, ay_c;
  logic [MAG_W-1:0]            s1_ax_r, s1_ay_r;
  logic                        s1_vxn_r, s1_vyn_r;
  logic [dcs_pkg::MASS_BITS-1:0] s1_m1_r, s1_m2_r;
  logic [NSQ_W-1:0]            sqx_c, sqy_c;
  dcs_pkg::dcs_work_t          s2_r;

  assign en      = !s2_valid_r || !wq_full;
  assign full    = !en;
  assign wq_push = s2_valid_r && !wq_full;
  assign wq_data = s2_r;

  assign vx_c = MAG_W'(in_data.body1_x) - MAG_W'(in_data.body2_x);
  assign vy_c = MAG_W'(in_data.body1_y) - MAG_W'(in_data.body2_y);
  assign ax_c = vx_c[MAG_W-1] ? MAG_W'(-vx_c) : MAG_W'(vx_c);
  assign ay_c = vy_c[MAG_W-1] ? MAG_W'(-vy_c) : MAG_W'(vy_c);

  assign sqx_c = NSQ_W'(s1_ax_r) * NSQ_W'(s1_ax_r);
  assign sqy_c = NSQ_W'(s1_ay_r) * NSQ_W'(s1_ay_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= push;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax_r     <= ax_c;
      s1_ay_r     <= ay_c;
      s1_vxn_r    <= vx_c[MAG_W-1];
      s1_vyn_r    <= vy_c[MAG_W-1];
      s1_m1_r     <= in_data.body1_mass;
      s1_m2_r     <= in_data.body2_mass;
      s2_r.ax     <= s1_ax_r;
      s2_r.ay     <= s1_ay_r;
      s2_r.vx_neg <= s1_vxn_r;
      s2_r.vy_neg <= s1_vyn_r;
      s2_r.nsq    <= sqx_c + sqy_c;
      s2_r.m1     <= s1_m1_r;
      s2_r.m2     <= s1_m2_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dcs_back.sv =====
// back end: break test, serial square root and divides, mass split and saturation
`default_nettype none

module dcs_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dcs_pkg::dcs_cfg_t  cfg,
  input  wire logic               wq_empty,
  output logic                    wq_pop,
  input  wire dcs_pkg::dcs_work_t wq_data,
  input  wire logic               oq_full,
  output logic                    oq_push,
  output dcs_pkg::dcs_out_t       oq_data
);

  localparam int POS_BITS = dcs_pkg::POS_BITS;
  localparam int MASS_W   = dcs_pkg::MASS_BITS;
  localparam int MAG_W    = dcs_pkg::MAG_W;
  localparam int NSQ_W    = dcs_pkg::NSQ_W;
  localparam int LIM_W    = dcs_pkg::REST_W + dcs_pkg::STR_W;
  localparam int LIM_LO   = (LIM_W + 1) / 2;
  localparam int LIM_HI   = LIM_W - LIM_LO;
  localparam int CMP_A    = 2 * LIM_W;
  localparam int CMP_B    = NSQ_W + dcs_pkg::STR_FRAC2;
  localparam int CMP_W    = (CMP_A > CMP_B) ? CMP_A : CMP_B;
  localparam int MUL_T    = (MAG_W > MASS_W) ? MAG_W : MASS_W;
  localparam int MUL_W    = (MUL_T > LIM_LO) ? MUL_T : LIM_LO;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int DIVR_W   = (MAG_W + 1 > MASS_W + 1) ? MAG_W + 1 : MASS_W + 1;
  localparam int CNT_W    = $clog2(MAG_W);
  localparam int N_OPS    = 6;
  localparam int OP_W     = $clog2(N_OPS);
  localparam logic [OP_W-1:0] OP_TX  = OP_W'(0);
  localparam logic [OP_W-1:0] OP_TY  = OP_W'(1);
  localparam logic [OP_W-1:0] OP_U1X = OP_W'(2);
  localparam logic [OP_W-1:0] OP_U1Y = OP_W'(3);
  localparam logic [OP_W-1:0] OP_U2X = OP_W'(4);
  localparam logic [OP_W-1:0] OP_U2Y = OP_W'(5);
  localparam logic [MAG_W-1:0] POS_MAX = MAG_W'((64'd1 << (POS_BITS - 1)) - 64'd1);

  function automatic logic [POS_BITS-1:0] sat_pos(input logic [MAG_W-1:0] mag,
                                                  input logic neg);
    logic [MAG_W-1:0] m;
    logic [MAG_W-1:0] n;
    if (!neg) begin
      m = (mag > POS_MAX) ? POS_MAX : mag;
      return m[POS_BITS-1:0];
    end
    m = (mag > POS_MAX + 1'b1) ? POS_MAX + 1'b1 : mag;
    n = ~m + 1'b1;
    return n[POS_BITS-1:0];
  endfunction

  dcs_pkg::dcs_state_t state_r, state_nxt;
  dcs_pkg::dcs_work_t  wk_r, wk_nxt;
  logic [LIM_W-1:0]    limit_r, limit_nxt;
  logic [CMP_W-1:0]    lsq_r, lsq_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [NSQ_W-1:0]    sq_n_r, sq_n_nxt;
  logic [MAG_W+1:0]    sq_rem_r, sq_rem_nxt;
  logic [MAG_W-1:0]    root_r, root_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [MAG_W-1:0]    dmag_r, dmag_nxt;
  logic                dneg_r, dneg_nxt;
  logic                split_r, split_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [DIVR_W-1:0]   dv_rem_r, dv_rem_nxt;
  logic [MAG_W-1:0]    dv_num_r, dv_num_nxt;
  logic [MAG_W-1:0]    dv_q_r, dv_q_nxt;
  logic [DIVR_W-1:0]   dv_d_r, dv_d_nxt;
  logic [MAG_W-1:0]    qres_r [N_OPS];
  logic [MAG_W-1:0]    qres_nxt [N_OPS];
  logic                broken_r, broken_nxt;
  logic                moved_r, moved_nxt;

  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [MAG_W+3:0]    sq_sh, sq_trial;
  logic                sq_ge;
  logic [DIVR_W:0]     dv_sh;
  logic                dv_ge, dv_up;
  logic [DIVR_W-1:0]   div_d;
  logic [MAG_W:0]      delta_c;
  logic                brk_c;
  logic [CMP_W-1:0]    lhs_c;
  logic                tneg_x, tneg_y;
  logic [MAG_W-1:0]    u1x, u1y, u2x, u2y;

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      dcs_pkg::ST_L0: begin
        mul_a = MUL_W'(limit_r[LIM_W-1:LIM_LO]);
        mul_b = MUL_W'(limit_r[LIM_W-1:LIM_LO]);
      end
      dcs_pkg::ST_L1: begin
        mul_a = MUL_W'(limit_r[LIM_W-1:LIM_LO]);
        mul_b = MUL_W'(limit_r[LIM_LO-1:0]);
      end
      dcs_pkg::ST_L2: begin
        mul_a = MUL_W'(limit_r[LIM_LO-1:0]);
        mul_b = MUL_W'(limit_r[LIM_LO-1:0]);
      end
      dcs_pkg::ST_MUL: begin
        case (op_r)
          OP_TX: begin
            mul_a = MUL_W'(wk_r.ax);
            mul_b = MUL_W'(dmag_r);
          end
          OP_TY: begin
            mul_a = MUL_W'(wk_r.ay);
            mul_b = MUL_W'(dmag_r);
          end
          OP_U1X: begin
            mul_a = MUL_W'(qres_r[0]);
            mul_b = MUL_W'(wk_r.m2);
          end
          OP_U1Y: begin
            mul_a = MUL_W'(qres_r[1]);
            mul_b = MUL_W'(wk_r.m2);
          end
          OP_U2X: begin
            mul_a = MUL_W'(qres_r[0]);
            mul_b = MUL_W'(wk_r.m1);
          end
          OP_U2Y: begin
            mul_a = MUL_W'(qres_r[1]);
            mul_b = MUL_W'(wk_r.m1);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sq_sh    = {sq_rem_r, sq_n_r[NSQ_W-1 -: 2]};
  assign sq_trial = (MAG_W + 4)'({root_r, 2'b01});
  assign sq_ge    = (sq_sh >= sq_trial);

  assign dv_sh = {dv_rem_r, dv_num_r[MAG_W-1]};
  assign dv_ge = (dv_sh >= (DIVR_W + 1)'(dv_d_r));
  assign dv_up = (dv_rem_r >= (dv_d_r - dv_rem_r));
  assign div_d = (op_r == OP_TX || op_r == OP_TY) ? DIVR_W'({root_r, 1'b0})
                                                  : DIVR_W'(wk_r.m1) + DIVR_W'(wk_r.m2);

  assign delta_c = (MAG_W + 1)'(root_r) - (MAG_W + 1)'(cfg.rest_length);
  assign lhs_c   = CMP_W'(wk_r.nsq) << dcs_pkg::STR_FRAC2;
  assign brk_c   = (cfg.max_stretch != '0) && (lhs_c > lsq_r);

  always_comb begin
    state_nxt  = state_r;
    wk_nxt     = wk_r;
    limit_nxt  = limit_r;
    lsq_nxt    = lsq_r;
    prod_nxt   = prod_r;
    sq_n_nxt   = sq_n_r;
    sq_rem_nxt = sq_rem_r;
    root_nxt   = root_r;
    cnt_nxt    = cnt_r;
    dmag_nxt   = dmag_r;
    dneg_nxt   = dneg_r;
    split_nxt  = split_r;
    op_nxt     = op_r;
    dv_rem_nxt = dv_rem_r;
    dv_num_nxt = dv_num_r;
    dv_q_nxt   = dv_q_r;
    dv_d_nxt   = dv_d_r;
    qres_nxt   = qres_r;
    broken_nxt = broken_r;
    moved_nxt  = moved_r;
    wq_pop     = 1'b0;
    oq_push    = 1'b0;
    case (state_r)
      dcs_pkg::ST_IDLE: begin
        if (!wq_empty) begin
          wq_pop    = 1'b1;
          wk_nxt    = wq_data;
          state_nxt = dcs_pkg::ST_LIM;
        end
      end
      dcs_pkg::ST_LIM: begin
        limit_nxt = LIM_W'(cfg.rest_length) * LIM_W'(cfg.max_stretch);
        state_nxt = dcs_pkg::ST_L0;
      end
      dcs_pkg::ST_L0: begin
        prod_nxt  = mul_p;
        state_nxt = dcs_pkg::ST_L1;
      end
      dcs_pkg::ST_L1: begin
        lsq_nxt   = CMP_W'(prod_r) << (2 * LIM_LO);
        prod_nxt  = mul_p;
        state_nxt = dcs_pkg::ST_L2;
      end
      dcs_pkg::ST_L2: begin
        lsq_nxt   = lsq_r + (CMP_W'(prod_r) << (LIM_LO + 1));
        prod_nxt  = mul_p;
        state_nxt = dcs_pkg::ST_L3;
      end
      dcs_pkg::ST_L3: begin
        lsq_nxt   = lsq_r + CMP_W'(prod_r);
        state_nxt = dcs_pkg::ST_BRK;
      end
      dcs_pkg::ST_BRK: begin
        broken_nxt = brk_c;
        moved_nxt  = 1'b0;
        sq_n_nxt   = wk_r.nsq;
        sq_rem_nxt = '0;
        root_nxt   = '0;
        cnt_nxt    = '0;
        state_nxt  = brk_c ? dcs_pkg::ST_FIN : dcs_pkg::ST_SQRT;
      end
      dcs_pkg::ST_SQRT: begin
        sq_rem_nxt = sq_ge ? (MAG_W + 2)'(sq_sh - sq_trial) : (MAG_W + 2)'(sq_sh);
        root_nxt   = {root_r[MAG_W-2:0], sq_ge};
        sq_n_nxt   = sq_n_r << 2;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          state_nxt = dcs_pkg::ST_DELTA;
        end
      end
      dcs_pkg::ST_DELTA: begin
        dneg_nxt  = delta_c[MAG_W];
        dmag_nxt  = delta_c[MAG_W] ? MAG_W'(-delta_c) : MAG_W'(delta_c);
        split_nxt = (wk_r.m1 != '0) && (wk_r.m2 != '0) && !delta_c[MAG_W];
        op_nxt    = OP_TX;
        if (root_r == '0) begin
          state_nxt = dcs_pkg::ST_FIN;
        end else if (cfg.only_tension && (delta_c[MAG_W] || delta_c == '0)) begin
          state_nxt = dcs_pkg::ST_FIN;
        end else begin
          moved_nxt = 1'b1;
          state_nxt = dcs_pkg::ST_MUL;
        end
      end
      dcs_pkg::ST_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = dcs_pkg::ST_DLD;
      end
      dcs_pkg::ST_DLD: begin
        dv_rem_nxt = DIVR_W'(prod_r[PROD_W-1:MAG_W]);
        dv_num_nxt = prod_r[MAG_W-1:0];
        dv_q_nxt   = '0;
        dv_d_nxt   = div_d;
        cnt_nxt    = '0;
        state_nxt  = dcs_pkg::ST_DIV;
      end
      dcs_pkg::ST_DIV: begin
        dv_rem_nxt = dv_ge ? DIVR_W'(dv_sh - (DIVR_W + 1)'(dv_d_r)) : DIVR_W'(dv_sh);
        dv_q_nxt   = {dv_q_r[MAG_W-2:0], dv_ge};
        dv_num_nxt = dv_num_r << 1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          state_nxt = dcs_pkg::ST_RND;
        end
      end
      dcs_pkg::ST_RND: begin
        qres_nxt[op_r] = dv_q_r + MAG_W'(dv_up);
        if (op_r == OP_U2Y || (op_r == OP_TY && !split_r)) begin
          state_nxt = dcs_pkg::ST_FIN;
        end else begin
          op_nxt    = op_r + 1'b1;
          state_nxt = dcs_pkg::ST_MUL;
        end
      end
      dcs_pkg::ST_FIN: begin
        if (!oq_full) begin
          oq_push   = 1'b1;
          state_nxt = dcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dcs_pkg::ST_IDLE;
      end
    endcase
  end

  assign tneg_x = (wk_r.vx_neg != dneg_r) && (qres_r[0] != '0);
  assign tneg_y = (wk_r.vy_neg != dneg_r) && (qres_r[1] != '0);
  assign u1x    = split_r ? qres_r[2] : qres_r[0];
  assign u1y    = split_r ? qres_r[3] : qres_r[1];
  assign u2x    = split_r ? qres_r[4] : qres_r[0];
  assign u2y    = split_r ? qres_r[5] : qres_r[1];

  always_comb begin
    oq_data.broken  = broken_r;
    oq_data.moved   = moved_r;
    oq_data.move1_x = '0;
    oq_data.move1_y = '0;
    oq_data.move2_x = '0;
    oq_data.move2_y = '0;
    if (moved_r) begin
      oq_data.move1_x = sat_pos(u1x, !tneg_x && (qres_r[0] != '0));
      oq_data.move1_y = sat_pos(u1y, !tneg_y && (qres_r[1] != '0));
      oq_data.move2_x = sat_pos(u2x, tneg_x);
      oq_data.move2_y = sat_pos(u2y, tneg_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dcs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wk_r     <= wk_nxt;
    limit_r  <= limit_nxt;
    lsq_r    <= lsq_nxt;
    prod_r   <= prod_nxt;
    sq_n_r   <= sq_n_nxt;
    sq_rem_r <= sq_rem_nxt;
    root_r   <= root_nxt;
    cnt_r    <= cnt_nxt;
    dmag_r   <= dmag_nxt;
    dneg_r   <= dneg_nxt;
    split_r  <= split_nxt;
    op_r     <= op_nxt;
    dv_rem_r <= dv_rem_nxt;
    dv_num_r <= dv_num_nxt;
    dv_q_r   <= dv_q_nxt;
    dv_d_r   <= dv_d_nxt;
    qres_r   <= qres_nxt;
    broken_r <= broken_nxt;
    moved_r  <= moved_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/distance_constraint_solver_top.sv =====
// top level of the distance constraint solver: config registers, queues and both ends
// The front end takes one transaction per cycle while its work queue has room and
// works out the separation and squared distance in two pipeline stages. The back end
// handles one transaction at a time with a shared multiplier and a one-bit-per-cycle
// square root and divide loop. A broken stick ends after the break test, zero distance
// or a stick that is not stretched in tension-only mode ends after the square root, and
// divides run twice without a mass split and six times with one. Results wait in an
// output queue so the back end keeps working while the consumer stalls and that queue
// has room. A configuration write also affects a transaction already in the back end.
`default_nettype none

`include "distance_constraint_solver_top_assert.svh"

module distance_constraint_solver_top #(
  parameter int WQ_DEPTH = dcs_pkg::WQ_DEPTH,
  parameter int OQ_DEPTH = dcs_pkg::OQ_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              push,
  output logic                                   full,
  input  wire dcs_pkg::dcs_in_t                  in_data,
  output logic                                   empty,
  input  wire logic                              pop,
  output dcs_pkg::dcs_out_t                      out_data,
  input  wire logic                              cfg_we,
  input  wire logic [dcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dcs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  dcs_pkg::dcs_cfg_t  cfg_r;
  logic               wq_push, wq_full, wq_pop, wq_empty;
  dcs_pkg::dcs_work_t wq_in, wq_out;
  logic               oq_push, oq_full;
  dcs_pkg::dcs_out_t  oq_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dcs_pkg::CFG_REST:    cfg_r.rest_length  <= cfg_wdata[dcs_pkg::REST_W-1:0];
        dcs_pkg::CFG_STRETCH: cfg_r.max_stretch  <= cfg_wdata[dcs_pkg::STR_W-1:0];
        dcs_pkg::CFG_TENSION: cfg_r.only_tension <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  dcs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .wq_push (wq_push),
    .wq_full (wq_full),
    .wq_data (wq_in)
  );

  dcs_fifo #(
    .data_t (dcs_pkg::dcs_work_t),
    .DEPTH  (WQ_DEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (wq_push),
    .full  (wq_full),
    .din   (wq_in),
    .pop   (wq_pop),
    .empty (wq_empty),
    .dout  (wq_out)
  );

  dcs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .wq_empty (wq_empty),
    .wq_pop   (wq_pop),
    .wq_data  (wq_out),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_data  (oq_in)
  );

  dcs_fifo #(
    .data_t (dcs_pkg::dcs_out_t),
    .DEPTH  (OQ_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .full  (oq_full),
    .din   (oq_in),
    .pop   (pop),
    .empty (empty),
    .dout  (out_data)
  );

  `DCS_ASSERT_IMP(a_broken_no_move, !empty && out_data.broken, !out_data.moved && out_data.move1_x == '0 && out_data.move2_y == '0, "broken transaction carries a move")
  `DCS_ASSERT_IMP(a_still_zero, !empty && !out_data.moved, out_data.move1_y == '0 && out_data.move2_x == '0, "unmoved transaction carries a move")
  `DCS_ASSERT_IMP(a_full_from_queue, full, wq_full, "front stalls with room in work queue")

endmodule

`default_nettype wire

// ===== dv/dcs_checker.sv =====
// checker for the distance constraint solver: watches both channels, predicts and compares
module dcs_checker
  import dcs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire logic                  full,
  input  wire dcs_in_t               in_data,
  input  wire logic                  empty,
  input  wire logic                  pop,
  input  wire dcs_out_t              out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [REST_W-1:0] rest_q;
  logic [STR_W-1:0]  stretch_q;
  logic              tension_q;
  dcs_out_t          expected_moves[$];

  assign pending = expected_moves.size();

  function automatic logic [127:0] div_round(logic [127:0] n, logic [127:0] d);
    logic [127:0] q;
    logic [127:0] r;
    if (d == '0) return '0;
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 128'd1;
    if (q > (128'd1 << 63)) q = 128'd1 << 63;
    return q;
  endfunction

  function automatic logic [POS_BITS-1:0] saturate(logic [127:0] mag, logic neg);
    logic [127:0] mx;
    mx = (128'd1 << (POS_BITS - 1)) - 128'd1;
    if (!neg) return (mag > mx) ? mx[POS_BITS-1:0] : mag[POS_BITS-1:0];
    if (mag > mx + 128'd1) mag = mx + 128'd1;
    return -mag[POS_BITS-1:0];
  endfunction

  function automatic dcs_out_t solve_stick(dcs_in_t t);
    dcs_out_t o;
    longint vx, vy, delta;
    logic [127:0] ax, ay, nsq, lim, span, c, dmag, txm, tym, msum, u;
    logic txn, tyn, split;
    o = '0;
    vx = longint'(t.body1_x) - longint'(t.body2_x);
    vy = longint'(t.body1_y) - longint'(t.body2_y);
    ax = 128'((vx < 0) ? -vx : vx);
    ay = 128'((vy < 0) ? -vy : vy);
    nsq = ax * ax + ay * ay;
    lim = 128'(rest_q) * 128'(stretch_q);
    if (stretch_q != 0 && (nsq << 16) > lim * lim) begin
      o.broken = 1'b1;
      return o;
    end
    span = '0;
    for (int b = 40; b >= 0; b--) begin
      c = span | (128'd1 << b);
      if (c * c <= nsq) span = c;
    end
    if (span == '0) return o;
    delta = longint'(span) - longint'(rest_q);
    if (tension_q && delta <= 0) return o;
    dmag = 128'((delta < 0) ? -delta : delta);
    txm = div_round(ax * dmag, 128'd2 * span);
    tym = div_round(ay * dmag, 128'd2 * span);
    txn = ((vx < 0) != (delta < 0)) && txm != '0;
    tyn = ((vy < 0) != (delta < 0)) && tym != '0;
    split = t.body1_mass != 0 && t.body2_mass != 0 && delta >= 0;
    msum = 128'(t.body1_mass) + 128'(t.body2_mass);
    u = split ? div_round(txm * 128'(t.body2_mass), msum) : txm;
    o.move1_x = saturate(u, !txn && txm != '0);
    u = split ? div_round(tym * 128'(t.body2_mass), msum) : tym;
    o.move1_y = saturate(u, !tyn && tym != '0);
    u = split ? div_round(txm * 128'(t.body1_mass), msum) : txm;
    o.move2_x = saturate(u, txn);
    u = split ? div_round(tym * 128'(t.body1_mass), msum) : tym;
    o.move2_y = saturate(u, tyn);
    o.moved = 1'b1;
    return o;
  endfunction

  always @(posedge clk) begin
    dcs_out_t e;
    if (!rst_n) begin
      rest_q <= '0;
      stretch_q <= '0;
      tension_q <= 1'b0;
      fail_count <= 0;
      expected_moves.delete();
    end else begin
      if (push && !full) expected_moves.push_back(solve_stick(in_data));
      if (pop && !empty) begin
        if (expected_moves.size() == 0) begin
          $display("%0t: unexpected transaction, actual %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_moves.pop_front();
          if (e !== out_data) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, e, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_REST:    rest_q <= cfg_wdata[REST_W-1:0];
          CFG_STRETCH: stretch_q <= cfg_wdata[STR_W-1:0];
          CFG_TENSION: tension_q <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== dv/tb_distance_constraint_solver_top.sv =====
// testbench top for the distance constraint solver: stimulus, configuration and verdict
module tb_distance_constraint_solver_top;
  import dcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  dcs_in_t in_data = '0;
  logic full, empty;
  dcs_out_t out_data;
  int fail_count, pending;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  always #10 clk = ~clk;

  distance_constraint_solver_top u_top (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  dcs_checker u_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver stall pattern
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (hold_off) pop <= 1'b0;
    else if (r < 30) pop <= 1'b1;
    else if (r < 50) pop <= 1'b0;
    else pop <= ~pop;
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic signed [POS_BITS-1:0] rand_pos(int mode);
    case (mode)
      0: return $signed(POS_BITS'($urandom));
      1: return POS_BITS'(int'($urandom_range(0, 8000)) - 4000);
      default: return POS_BITS'(int'($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(int rest, int str, int ten);
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    write_reg(CFG_REST, CFG_DATA_W'(rest));
    write_reg(CFG_STRETCH, CFG_DATA_W'(str));
    write_reg(CFG_TENSION, CFG_DATA_W'(ten));
    write_reg(2'd3, CFG_DATA_W'($urandom));
  endtask

  task automatic send(dcs_in_t t, bit gap);
    push <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (full) @(posedge clk);
    if (gap) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic random_burst(int count, int mode);
    dcs_in_t t;
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      t.body1_x = rand_pos(mode);
      t.body1_y = rand_pos(mode);
      t.body2_x = ($urandom_range(0, 9) == 0) ? t.body1_x : rand_pos(mode);
      t.body2_y = ($urandom_range(0, 9) == 0) ? t.body1_y : rand_pos(mode);
      t.body1_mass = ($urandom_range(0, 7) == 0) ? '0 : MASS_BITS'($urandom);
      t.body2_mass = ($urandom_range(0, 7) == 0) ? '0 : MASS_BITS'($urandom);
      if (burst == 0) burst = $urandom_range(1, 20);
      burst--;
      send(t, burst == 0 && $urandom_range(0, 3) != 0);
    end
    push <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    dcs_in_t t;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, zero distance, exact rest length, broken, masses
    configure(256 * 100, 512, 0);
    t = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 16'hFFFF, 16'hFFFF};
    send(t, 0);
    t = '{24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 16'h0, 16'hFFFF};
    send(t, 0);
    t = '{24'sd100, -24'sd7, 24'sd100, -24'sd7, 16'd3, 16'd5};
    send(t, 0);
    t = '{24'sd25600, 24'sd0, 24'sd0, 24'sd0, 16'd3, 16'd5};
    send(t, 0);
    t = '{24'sd0, 24'sd30000, 24'sd0, 24'sd0, 16'd1, 16'd0};
    send(t, 0);
    t = '{-24'sd300, 24'sd400, 24'sd0, 24'sd0, 16'hFFFF, 16'd1};
    send(t, 0);
    t = '{24'sd60000, 24'sd0, 24'sd0, 24'sd0, 16'd2, 16'd2};
    send(t, 1);
    configure(256 * 100, 0, 1);
    send('{24'sd25600, 24'sd0, 24'sd0, 24'sd0, 16'd1, 16'd1}, 0);
    send('{24'sd1000, 24'sd0, 24'sd0, 24'sd0, 16'd1, 16'd1}, 0);
    send('{24'sd30000, -24'sd100, 24'sd0, 24'sd0, 16'd7, 16'd9}, 0);
    send('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 16'd1, 16'd0}, 1);
    configure(23'h7FFFFF, 12'hFFF, 0);
    random_burst(10, 0);
    configure(0, 0, 0);
    random_burst(10, 0);
    // random phases
    configure($urandom_range(0, 6000), $urandom_range(200, 700), 0);
    random_burst(200, 1);
    configure($urandom_range(0, 6000), 0, 1);
    random_burst(200, 1);
    // long receiver hold-off while items keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      random_burst(40, 2);
    join
    configure($urandom_range(0, 50000), $urandom_range(1, 4095), $urandom_range(0, 1));
    random_burst(200, 2);
    configure($urandom, $urandom_range(0, 4095), 0);
    random_burst(150, 0);
    configure($urandom_range(0, 6000), $urandom_range(250, 400), 1);
    random_burst(200, 1);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
